[rtl/prq_pkg.sv]
// ----------------------------------------------------------------------------
// prq_pkg: shared constants, codes and helpers of the priority ready queue
// Sizes of the id pool and the level set, field widths and the two
// priority encoders used to pick a free id and the best non-empty level.
// ----------------------------------------------------------------------------
package prq_pkg;

   // sizing
   localparam int NUM_LEVELS = 64;
   localparam int NUM_IDS    = 32;
   localparam int TAG_WIDTH  = 32;
   localparam int LVL_W      = $clog2(NUM_LEVELS);
   localparam int ID_W       = $clog2(NUM_IDS);

   // item field widths
   localparam int ID_FIELD_W  = 6;
   localparam int PRIO_W      = 7;
   localparam int TAG_FIELD_W = 32;
   localparam int CNT_W       = 6;

   // item kinds
   localparam logic KIND_ADD    = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   // lowest id whose used bit is clear
   function automatic logic [ID_W-1:0] lowest_free_id(input logic [NUM_IDS-1:0] used);
      logic [ID_W-1:0] idx;
      idx = '0;
      for (int i = NUM_IDS - 1; i >= 0; i--) begin
         if (!used[i]) begin
            idx = ID_W'(i);
         end
      end
      return idx;
   endfunction

   // lowest (best) level whose non-empty bit is set
   function automatic logic [LVL_W-1:0] best_level(input logic [NUM_LEVELS-1:0] busy);
      logic [LVL_W-1:0] idx;
      idx = '0;
      for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
         if (busy[i]) begin
            idx = LVL_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

[rtl/priority_ready_queue_core.sv]
// ----------------------------------------------------------------------------
// priority_ready_queue_core: job ready queue, one FIFO per priority level
// Add items store a job under a free id at the tail of its level; remove
// items pop the head of the best non-empty level. Head/tail per level, the
// next-id links and the job tags live in RAMs; used and non-empty maps and
// the job count live in flops.
// Response path: rsp_tvalid is set from ST_LOOKUP for an add, a rejected
//   add or a remove on an empty queue, and from ST_FETCH for a successful
//   remove, after the chain of registered RAM reads (level word, then link
//   and tag at the head id); both wait while the output register is full.
// Flow: a new item is taken only in ST_IDLE, once the previous one is done;
//   it is taken while the previous result waits in the output register.
// Reset: synchronous; clears maps, count and control, no RAM clearing pass.
// ----------------------------------------------------------------------------
module priority_ready_queue_core
   import prq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // requested_id[5:0], priority_req[12:6], job_tag[44:13]
   input  logic        req_tuser,  // kind
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // job_id[5:0], job_priority[12:6], job_tag_out[44:13],
                                   // queue_count[50:45]
   output logic        rsp_tuser   // done_res
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_FETCH
   } state_type;

   // control and item registers
   state_type               state_ff, state_in;
   logic                    kind_ff, kind_in;
   logic                    ok_ff, ok_in;
   logic [LVL_W-1:0]        lvl_ff, lvl_in;
   logic [ID_W-1:0]         slot_ff, slot_in;
   logic [TAG_WIDTH-1:0]    tag_ff, tag_in;
   logic [NUM_IDS-1:0]      used_ff, used_in;
   logic [NUM_LEVELS-1:0]   busy_ff, busy_in;
   logic [CNT_W-1:0]        count_ff, count_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_done_ff, rsp_done_in;
   logic [ID_FIELD_W-1:0]   rsp_id_ff, rsp_id_in;
   logic [PRIO_W-1:0]       rsp_prio_ff, rsp_prio_in;
   logic [TAG_FIELD_W-1:0]  rsp_tag_ff, rsp_tag_in;
   logic [CNT_W-1:0]        rsp_count_ff, rsp_count_in;

   // RAM ports
   logic                    lvl_we;
   logic [LVL_W-1:0]        lvl_rd_addr;
   logic [2*ID_W-1:0]       lvl_wr_data, lvl_rd_data;
   logic                    link_we;
   logic [ID_W-1:0]         link_wr_addr, link_wr_data, link_rd_data;
   logic                    tag_we;
   logic [TAG_WIDTH-1:0]    tag_rd_data;

   // request fields
   logic [ID_FIELD_W-1:0]   in_req_id, req_m1;
   logic [PRIO_W-1:0]       in_prio, prio_m1;
   logic [TAG_FIELD_W-1:0]  in_tag;
   logic                    accept, out_free;
   logic                    req_free, prio_ok;
   logic [LVL_W-1:0]        lvl_sel;
   logic [ID_W-1:0]         head_id, tail_id;

   assign in_req_id = req_tdata[5:0];
   assign in_prio   = req_tdata[12:6];
   assign in_tag    = req_tdata[44:13];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // decode of the add item
   assign req_m1   = in_req_id - ID_FIELD_W'(1);
   assign prio_m1  = in_prio - PRIO_W'(1);
   assign req_free = (in_req_id != '0) && (in_req_id <= ID_FIELD_W'(NUM_IDS))
                     && !used_ff[req_m1[ID_W-1:0]];
   assign prio_ok  = (in_prio != '0) && (in_prio <= PRIO_W'(NUM_LEVELS));

   // level looked up: the item's own on add, the best busy one on remove
   assign lvl_sel     = (req_tuser == KIND_ADD) ? prio_m1[LVL_W-1:0] : best_level(busy_ff);
   assign lvl_rd_addr = (state_ff == ST_IDLE) ? lvl_sel : lvl_ff;

   assign head_id = lvl_rd_data[2*ID_W-1:ID_W];
   assign tail_id = lvl_rd_data[ID_W-1:0];

   // head/tail word per level
   prq_ram #(.WIDTH(2 * ID_W), .DEPTH(NUM_LEVELS)) u_level_ram (
      .clock   (clock),
      .wr_en   (lvl_we),
      .wr_addr (lvl_ff),
      .wr_data (lvl_wr_data),
      .rd_addr (lvl_rd_addr),
      .rd_data (lvl_rd_data)
   );

   // next id in the same level, indexed by id
   prq_ram #(.WIDTH(ID_W), .DEPTH(NUM_IDS)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data),
      .rd_addr (head_id),
      .rd_data (link_rd_data)
   );

   // job tag, indexed by id
   prq_ram #(.WIDTH(TAG_WIDTH), .DEPTH(NUM_IDS)) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_we),
      .wr_addr (slot_ff),
      .wr_data (tag_ff),
      .rd_addr (head_id),
      .rd_data (tag_rd_data)
   );

   // sequencer: capture, look up level, fetch head entry (successful remove only), update
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      ok_in        = ok_ff;
      lvl_in       = lvl_ff;
      slot_in      = slot_ff;
      tag_in       = tag_ff;
      used_in      = used_ff;
      busy_in      = busy_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_done_in  = rsp_done_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_prio_in  = rsp_prio_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_count_in = rsp_count_ff;
      lvl_we       = 1'b0;
      lvl_wr_data  = lvl_rd_data;
      link_we      = 1'b0;
      link_wr_addr = tail_id;
      link_wr_data = slot_ff;
      tag_we       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in = req_tuser;
               lvl_in  = lvl_sel;
               tag_in  = in_tag[TAG_WIDTH-1:0];
               if (req_tuser == KIND_ADD) begin
                  slot_in = req_free ? req_m1[ID_W-1:0] : lowest_free_id(used_ff);
                  ok_in   = prio_ok && !(&used_ff);
               end else begin
                  ok_in   = |busy_ff;
               end
               state_in = ST_LOOKUP;
            end
         end

         ST_LOOKUP: begin
            if (kind_ff == KIND_REMOVE && ok_ff) begin
               state_in = ST_FETCH;
            end else if (out_free) begin
               // add, or rejected / empty item
               rsp_valid_in = 1'b1;
               rsp_done_in  = ok_ff;
               rsp_id_in    = '0;
               rsp_prio_in  = '0;
               rsp_tag_in   = '0;
               rsp_count_in = count_ff;
               if (ok_ff) begin
                  tag_we = 1'b1;
                  lvl_we = 1'b1;
                  if (busy_ff[lvl_ff]) begin
                     link_we     = 1'b1;
                     lvl_wr_data = {head_id, slot_ff};
                  end else begin
                     lvl_wr_data = {slot_ff, slot_ff};
                  end
                  busy_in[lvl_ff]  = 1'b1;
                  used_in[slot_ff] = 1'b1;
                  count_in         = count_ff + CNT_W'(1);
                  rsp_id_in        = ID_FIELD_W'(slot_ff) + ID_FIELD_W'(1);
                  rsp_prio_in      = PRIO_W'(lvl_ff) + PRIO_W'(1);
                  rsp_tag_in       = TAG_FIELD_W'(tag_ff);
                  rsp_count_in     = count_ff + CNT_W'(1);
               end
               state_in = ST_IDLE;
            end
         end

         ST_FETCH: begin
            if (out_free) begin
               // pop head of the best level
               if (head_id == tail_id) begin
                  busy_in[lvl_ff] = 1'b0;
               end else begin
                  lvl_we      = 1'b1;
                  lvl_wr_data = {link_rd_data, tail_id};
               end
               used_in[head_id] = 1'b0;
               count_in         = (count_ff != '0) ? count_ff - CNT_W'(1) : count_ff;
               rsp_valid_in     = 1'b1;
               rsp_done_in      = 1'b1;
               rsp_id_in        = ID_FIELD_W'(head_id) + ID_FIELD_W'(1);
               rsp_prio_in      = PRIO_W'(lvl_ff) + PRIO_W'(1);
               rsp_tag_in       = TAG_FIELD_W'(tag_rd_data);
               rsp_count_in     = (count_ff != '0) ? count_ff - CNT_W'(1) : count_ff;
               state_in         = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         busy_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         kind_ff      <= kind_in;
         ok_ff        <= ok_in;
         lvl_ff       <= lvl_in;
         slot_ff      <= slot_in;
         tag_ff       <= tag_in;
         rsp_done_ff  <= rsp_done_in;
         rsp_id_ff    <= rsp_id_in;
         rsp_prio_ff  <= rsp_prio_in;
         rsp_tag_ff   <= rsp_tag_in;
         rsp_count_ff <= rsp_count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_done_ff;
   assign rsp_tdata  = {5'b0, rsp_count_ff, rsp_tag_ff, rsp_prio_ff, rsp_id_ff};

endmodule

[rtl/prq_ram.sv]
// ----------------------------------------------------------------------------
// prq_ram: generic single-clock RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module prq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for priority_ready_queue_core
// Drives add and remove items into the job queue and checks each response
// against a behavioral model of the per-level FIFOs, the id pool and the job
// count. Request and response sides idle in random bursts, save in the last
// random mix. Corner cases come first, then pool exhaustion, then two mixes.
// ----------------------------------------------------------------------------
module tb
   import prq_pkg::*;
();

   // one request item, unpacked
   typedef struct packed {
      logic                   kind;
      logic [ID_FIELD_W-1:0]  rid;
      logic [PRIO_W-1:0]      prio;
      logic [TAG_FIELD_W-1:0] tag;
   } job_req_type;

   // one response item, unpacked
   typedef struct packed {
      logic                   done;
      logic [ID_FIELD_W-1:0]  id;
      logic [PRIO_W-1:0]      prio;
      logic [TAG_FIELD_W-1:0] tag;
      logic [CNT_W-1:0]       count;
   } job_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;   // requested_id[5:0], priority_req[12:6], job_tag[44:13]
   logic        req_tuser;   // kind
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;   // job_id[5:0], job_priority[12:6], job_tag_out[44:13],
                             // queue_count[50:45]
   logic        rsp_tuser;   // done_res

   // shadow copy of the queue
   logic [NUM_IDS-1:0]    id_taken;
   logic [NUM_LEVELS-1:0] level_filled;
   int                    level_first [NUM_LEVELS];
   int                    level_last  [NUM_LEVELS];
   int                    id_follower [NUM_IDS];
   logic [TAG_WIDTH-1:0]  id_tag      [NUM_IDS];
   int                    jobs_queued;

   job_result_type job_results_due[$];

   bit idling_on;
   int err_count;
   int adds_taken, adds_refused, removes_hit, removes_empty;

   priority_ready_queue_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run limit
   initial begin
      #6000000;
      $display("FAIL priority_ready_queue_core");
      $finish;
   end

   // apply one item to the shadow queue and return the response it causes
   function automatic job_result_type apply_queue_op(job_req_type r);
      job_result_type res;
      int             slot;
      int             lvl;
      res  = '0;
      slot = -1;
      lvl  = -1;
      if (r.kind == KIND_ADD) begin
         if (r.prio >= 1 && r.prio <= NUM_LEVELS) begin
            // requested id if free, else lowest free id
            if (r.rid >= 1 && r.rid <= NUM_IDS && !id_taken[r.rid - 1]) begin
               slot = r.rid - 1;
            end else begin
               for (int i = 0; i < NUM_IDS; i++) begin
                  if (!id_taken[i] && slot < 0) slot = i;
               end
            end
            if (slot >= 0) begin
               lvl = r.prio - 1;
               id_tag[slot] = r.tag[TAG_WIDTH-1:0];
               if (level_filled[lvl]) begin
                  id_follower[level_last[lvl]] = slot;
                  level_last[lvl] = slot;
               end else begin
                  level_first[lvl]  = slot;
                  level_last[lvl]   = slot;
                  level_filled[lvl] = 1'b1;
               end
               id_taken[slot] = 1'b1;
               jobs_queued++;
               res.done = 1'b1;
               res.id   = ID_FIELD_W'(slot + 1);
               res.prio = r.prio;
               res.tag  = TAG_FIELD_W'(r.tag[TAG_WIDTH-1:0]);
            end
         end
      end else begin
         // best non-empty level, oldest job first
         for (int i = 0; i < NUM_LEVELS; i++) begin
            if (level_filled[i] && lvl < 0) lvl = i;
         end
         if (lvl >= 0) begin
            slot    = level_first[lvl];
            res.tag = TAG_FIELD_W'(id_tag[slot]);
            if (slot == level_last[lvl]) level_filled[lvl] = 1'b0;
            else level_first[lvl] = id_follower[slot];
            id_taken[slot] = 1'b0;
            if (jobs_queued > 0) jobs_queued--;
            res.done = 1'b1;
            res.id   = ID_FIELD_W'(slot + 1);
            res.prio = PRIO_W'(lvl + 1);
         end
      end
      res.count = CNT_W'(jobs_queued);
      return res;
   endfunction

   task automatic report_miss(string what, job_result_type want, job_result_type got);
      err_count++;
      if (err_count <= 10) begin
         $display("%0t %s: want done=%0d id=%0d prio=%0d tag=%h count=%0d", $time, what,
                  want.done, want.id, want.prio, want.tag, want.count);
         $display("%0t %s:  got done=%0d id=%0d prio=%0d tag=%h count=%0d", $time, what,
                  got.done, got.id, got.prio, got.tag, got.count);
      end
   endtask

   // monitor: check responses, then predict for accepted requests
   always @(posedge clock) begin
      job_req_type    r;
      job_result_type got, want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.done  = rsp_tuser;
            got.id    = rsp_tdata[5:0];
            got.prio  = rsp_tdata[12:6];
            got.tag   = rsp_tdata[44:13];
            got.count = rsp_tdata[50:45];
            if (job_results_due.size() == 0) begin
               report_miss("unexpected response", '0, got);
            end else begin
               want = job_results_due.pop_front();
               if (got.done !== want.done || got.id !== want.id || got.prio !== want.prio ||
                   got.tag !== want.tag || got.count !== want.count)
                  report_miss("mismatch", want, got);
            end
         end
         if (req_tvalid && req_tready) begin
            r.kind = req_tuser;
            r.rid  = req_tdata[5:0];
            r.prio = req_tdata[12:6];
            r.tag  = req_tdata[44:13];
            want = apply_queue_op(r);
            job_results_due.push_back(want);
            if (r.kind == KIND_ADD) begin
               if (want.done) adds_taken++;
               else adds_refused++;
            end else begin
               if (want.done) removes_hit++;
               else removes_empty++;
            end
         end
      end
   end

   // response side: random stall bursts while idling is on
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (idling_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 18) - 1) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // send one item; valid stays high across back-to-back items
   task automatic send_item(logic kind, logic [ID_FIELD_W-1:0] rid,
                            logic [PRIO_W-1:0] prio, logic [TAG_FIELD_W-1:0] tag);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18) - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {3'b000, tag, prio, rid};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_add(int rid, int prio, logic [TAG_FIELD_W-1:0] tag);
      send_item(KIND_ADD, ID_FIELD_W'(rid), PRIO_W'(prio), tag);
   endtask

   task automatic send_remove();
      // unused fields carry noise; the block must ignore them
      send_item(KIND_REMOVE, ID_FIELD_W'($urandom), PRIO_W'($urandom), $urandom);
   endtask

   // hold requests until every outstanding response has come back
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (job_results_due.size() != 0) @(posedge clock);
   endtask

   function automatic int pick_level();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 7) return $urandom_range(1, 4);
      if (sel < 9) return $urandom_range(1, NUM_LEVELS);
      if ($urandom_range(0, 1) == 0) return 0;
      return $urandom_range(NUM_LEVELS + 1, 127);
   endfunction

   function automatic int pick_id();
      if ($urandom_range(0, 4) != 0) return $urandom_range(1, NUM_IDS);
      return $urandom_range(0, 63);
   endfunction

   // corner cases: empty pop, id collisions, out-of-range ids and levels
   task automatic test_corner_cases();
      send_remove();                          // pop from empty queue
      send_add(1, 1, 32'h0000_0000);
      send_add(1, 1, 32'hFFFF_FFFF);          // id taken, lowest free id used
      send_add(0, NUM_LEVELS, 32'h1234_5678); // id 0 counts as taken
      send_add(63, 2, 32'hA5A5_A5A5);         // id above pool counts as taken
      send_add(NUM_IDS + 1, NUM_LEVELS, 32'h5A5A_5A5A);
      send_add(NUM_IDS, 1, 32'h8000_0001);
      send_add(5, 0, 32'hDEAD_BEEF);          // level 0: refused
      send_add(6, NUM_LEVELS + 1, 32'hCAFE_F00D);
      send_add(63, 127, 32'hFFFF_FFFF);       // all ones: refused
      send_add(31, 3, 32'h7FFF_FFFE);
      send_add(16, 32, 32'h0F0F_0F0F);
      send_add(8, 16, 32'hF0F0_F0F0);
      for (int i = 0; i < 11; i++) send_remove(); // last two hit an empty queue
   endtask

   // fill the id pool past capacity, pause, then drain past empty
   task automatic test_pool_exhaustion();
      for (int i = 0; i < NUM_IDS + 3; i++) send_add(pick_id(), $urandom_range(1, 8), $urandom);
      wait_drained();
      for (int i = 0; i < NUM_IDS + 2; i++) send_remove();
   endtask

   // random mix in phases that lean toward filling or emptying
   task automatic test_random_mix(int n_items);
      int add_pct;
      add_pct = 50;
      for (int i = 0; i < n_items; i++) begin
         if (i % 40 == 0) begin
            case ($urandom_range(0, 3))
               0: add_pct = 30;
               1: add_pct = 50;
               2: add_pct = 70;
               default: add_pct = 85;
            endcase
         end
         if (i % 150 == 75) wait_drained();
         if ($urandom_range(1, 100) <= add_pct) send_add(pick_id(), pick_level(), $urandom);
         else send_remove();
      end
   endtask

   // main sequence
   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = 1'b0;
      req_tdata  = '0;
      idling_on  = 1'b0;
      err_count  = 0;
      adds_taken = 0;
      adds_refused = 0;
      removes_hit  = 0;
      removes_empty = 0;
      id_taken     = '0;
      level_filled = '0;
      jobs_queued  = 0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
         level_first[i] = 0;
         level_last[i]  = 0;
      end
      for (int i = 0; i < NUM_IDS; i++) begin
         id_follower[i] = 0;
         id_tag[i]      = '0;
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      idling_on = 1'b1;
      test_corner_cases();
      test_pool_exhaustion();
      test_random_mix(600);
      idling_on = 1'b0;
      test_random_mix(120);

      // let the pipeline empty out
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (job_results_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (job_results_due.size() != 0) err_count++;

      $display("adds taken %0d, adds refused %0d, removes %0d, removes on empty %0d",
               adds_taken, adds_refused, removes_hit, removes_empty);
      $display("mismatches and stray responses: %0d", err_count);
      if (err_count == 0) begin
         $display("PASS priority_ready_queue_core");
      end else begin
         $display("FAIL priority_ready_queue_core");
      end
      $finish;
   end

endmodule
